>>> design/lcg_pkg.sv
package lcg_pkg;

    localparam int LCG_MAX_COLS  = 32;
    localparam int LCG_MAX_ROWS  = 4096;
    localparam int LCG_COL_W     = $clog2(LCG_MAX_COLS);
    localparam int LCG_COLS_W    = $clog2(LCG_MAX_COLS + 1);
    localparam int LCG_ROW_W     = 12;
    localparam int LCG_ROWS_W    = 13;
    localparam int LCG_QDEPTH    = 4;
    localparam int LCG_QPTR_W    = $clog2(LCG_QDEPTH);
    localparam int LCG_QCNT_W    = $clog2(LCG_QDEPTH + 1);
    localparam int LCG_ADDR_W    = 3;
    localparam int LCG_DATA_W    = 32;
    localparam int LCG_LIVE_LO   = 2;
    localparam int LCG_LIVE_HI   = 3;
    localparam int LCG_SHIFT_W   = LCG_MAX_COLS + 2;

    localparam logic LCG_REG_ROWS = 1'b0;
    localparam logic LCG_REG_COLS = 1'b1;

    typedef struct packed {
        logic                    has_a;
        logic                    alive_a;
        logic                    has_b;
        logic                    alive_b;
        logic [LCG_ROW_W-1:0]    row;
        logic [LCG_COL_W-1:0]    col;
        logic                    flush;
        logic [LCG_ROW_W-1:0]    frow;
        logic [LCG_COL_W-1:0]    flast;
        logic [LCG_MAX_COLS-1:0] fold;
        logic [LCG_MAX_COLS-1:0] fnew;
    } t_job;

    function automatic logic life_rule(input logic [8:0] w);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 9; b++) begin
            if (b != 4) begin
                n = n + 4'(w[b]);
            end
        end
        return (n == 4'(LCG_LIVE_HI)) || (w[4] && (n == 4'(LCG_LIVE_LO)));
    endfunction

    function automatic logic [LCG_COLS_W-1:0] eff_cols(input logic [LCG_COLS_W-1:0] v);
        logic [LCG_COLS_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LCG_COLS_W'(1);
        end else if (v > LCG_COLS_W'(LCG_MAX_COLS)) begin
            r = LCG_COLS_W'(LCG_MAX_COLS);
        end
        return r;
    endfunction

    function automatic logic [LCG_ROWS_W-1:0] eff_rows(input logic [LCG_ROWS_W-1:0] v);
        logic [LCG_ROWS_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = LCG_ROWS_W'(1);
        end else if (v > LCG_ROWS_W'(LCG_MAX_ROWS)) begin
            r = LCG_ROWS_W'(LCG_MAX_ROWS);
        end
        return r;
    endfunction

endpackage

>>> design/lcg_if.sv
interface lcg_cell_if;
    logic valid;
    logic ready;
    logic cell_alive;

    modport source (output valid, output cell_alive, input ready);
    modport sink   (input valid, input cell_alive, output ready);
endinterface

interface lcg_result_if;
    logic                          valid;
    logic                          ready;
    logic                          next_alive;
    logic [lcg_pkg::LCG_ROW_W-1:0] out_row;
    logic [lcg_pkg::LCG_COL_W-1:0] out_col;
    logic                          last_in_run;
    logic                          end_of_grid;

    modport source (output valid, output next_alive, output out_row, output out_col,
                    output last_in_run, output end_of_grid, input ready);
    modport sink   (input valid, input next_alive, input out_row, input out_col,
                    input last_in_run, input end_of_grid, output ready);
endinterface

>>> design/lcg_front.sv
module lcg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lcg_pkg::LCG_ROWS_W-1:0]  i_grid_rows,
    input  logic [lcg_pkg::LCG_COLS_W-1:0]  i_grid_cols,
    input  logic                            i_full,
    lcg_cell_if.sink                        i_cell,
    output logic                            o_push,
    output lcg_pkg::t_job                   o_job
);

    logic [lcg_pkg::LCG_MAX_COLS-1:0] r_old;
    logic [lcg_pkg::LCG_MAX_COLS-1:0] r_new;
    logic [8:0]                       r_win;
    logic [lcg_pkg::LCG_COL_W-1:0]    r_col;
    logic [lcg_pkg::LCG_ROW_W-1:0]    r_row;

    logic [lcg_pkg::LCG_COL_W-1:0]    n_col;
    logic [lcg_pkg::LCG_ROW_W-1:0]    n_row;
    logic [8:0]                       n_win;
    logic [lcg_pkg::LCG_MAX_COLS-1:0] n_old;
    logic [lcg_pkg::LCG_MAX_COLS-1:0] n_new;

    logic [lcg_pkg::LCG_COLS_W-1:0]   cols;
    logic [lcg_pkg::LCG_ROWS_W-1:0]   rows;
    logic                             restart;
    logic [lcg_pkg::LCG_COL_W-1:0]    j;
    logic [lcg_pkg::LCG_ROW_W-1:0]    i;
    logic                             a_bit;
    logic                             b_bit;
    logic [8:0]                       win_base;
    logic                             accept;
    logic                             last_cell;
    logic                             row_ge1;
    logic                             end_col;
    logic [lcg_pkg::LCG_COLS_W-1:0]   col_inc;
    logic [lcg_pkg::LCG_ROWS_W-1:0]   row_inc;
    logic [lcg_pkg::LCG_MAX_COLS-1:0] col_mask;

    assign cols    = lcg_pkg::eff_cols(i_grid_cols);
    assign rows    = lcg_pkg::eff_rows(i_grid_rows);
    assign restart = ({1'b0, r_col} >= cols) || ({1'b0, r_row} >= rows);
    assign j       = restart ? '0 : r_col;
    assign i       = restart ? '0 : r_row;
    assign row_ge1 = (i != '0);
    assign end_col = ({1'b0, j} == (cols - lcg_pkg::LCG_COLS_W'(1)));
    assign last_cell = end_col && ({1'b0, i} == (rows - lcg_pkg::LCG_ROWS_W'(1)));

    assign i_cell.ready = !i_full;
    assign accept       = i_cell.valid && !i_full;

    always_comb begin
        a_bit    = (i >= lcg_pkg::LCG_ROW_W'(2)) ? r_old[j] : 1'b0;
        b_bit    = row_ge1 ? r_new[j] : 1'b0;
        win_base = (j == '0) ? 9'd0 : r_win;
        n_win    = {i_cell.cell_alive, b_bit, a_bit, win_base[8:3]};
        n_old    = r_old;
        n_new    = r_new;
        n_old[j] = r_new[j];
        n_new[j] = i_cell.cell_alive;
        for (int k = 0; k < lcg_pkg::LCG_MAX_COLS; k++) begin
            col_mask[k] = (lcg_pkg::LCG_COLS_W'(k) < cols);
        end
    end

    always_comb begin
        col_inc = {1'b0, j} + lcg_pkg::LCG_COLS_W'(1);
        row_inc = {1'b0, i} + lcg_pkg::LCG_ROWS_W'(1);
        n_col   = col_inc[lcg_pkg::LCG_COL_W-1:0];
        n_row   = i;
        if (col_inc >= cols) begin
            n_col = '0;
            n_row = (row_inc >= rows) ? '0 : row_inc[lcg_pkg::LCG_ROW_W-1:0];
        end
    end

    always_comb begin
        o_job.has_a   = row_ge1 && (j != '0);
        o_job.alive_a = lcg_pkg::life_rule(n_win);
        o_job.has_b   = row_ge1 && end_col;
        o_job.alive_b = lcg_pkg::life_rule({3'b000, n_win[8:3]});
        o_job.row     = i - lcg_pkg::LCG_ROW_W'(1);
        o_job.col     = j;
        o_job.flush   = last_cell;
        o_job.frow    = i;
        o_job.flast   = j;
        o_job.fold    = row_ge1 ? (n_old & col_mask) : '0;
        o_job.fnew    = n_new & col_mask;
        o_push        = accept && (o_job.has_a || o_job.has_b || last_cell);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old <= n_old;
            r_new <= n_new;
        end
    end

endmodule

>>> design/lcg_queue.sv
module lcg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lcg_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output lcg_pkg::t_job o_job
);

    lcg_pkg::t_job                   r_mem [lcg_pkg::LCG_QDEPTH];
    logic [lcg_pkg::LCG_QPTR_W-1:0]  r_wp;
    logic [lcg_pkg::LCG_QPTR_W-1:0]  r_rp;
    logic [lcg_pkg::LCG_QCNT_W-1:0]  r_cnt;
    logic [lcg_pkg::LCG_QCNT_W-1:0]  n_cnt;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_cnt == lcg_pkg::LCG_QCNT_W'(lcg_pkg::LCG_QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + lcg_pkg::LCG_QCNT_W'(1);
            2'b01:   n_cnt = r_cnt - lcg_pkg::LCG_QCNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wp <= r_wp + lcg_pkg::LCG_QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + lcg_pkg::LCG_QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> design/lcg_back.sv
module lcg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  lcg_pkg::t_job i_job,
    output logic          o_pop,
    lcg_result_if.source  o_result
);

    logic                            r_busy;
    logic                            r_pa;
    logic                            r_pb;
    logic                            r_pf;
    logic                            r_alive_a;
    logic                            r_alive_b;
    logic [lcg_pkg::LCG_ROW_W-1:0]   r_row;
    logic [lcg_pkg::LCG_COL_W-1:0]   r_col;
    logic [lcg_pkg::LCG_ROW_W-1:0]   r_frow;
    logic [lcg_pkg::LCG_COL_W-1:0]   r_flast;
    logic [lcg_pkg::LCG_COL_W-1:0]   r_fc;
    logic [lcg_pkg::LCG_SHIFT_W-1:0] r_sold;
    logic [lcg_pkg::LCG_SHIFT_W-1:0] r_snew;

    logic                          r_ovalid;
    logic                          r_onext;
    logic [lcg_pkg::LCG_ROW_W-1:0] r_orow;
    logic [lcg_pkg::LCG_COL_W-1:0] r_ocol;
    logic                          r_olast;
    logic                          r_oeog;

    logic                          adv;
    logic                          em_alive;
    logic [lcg_pkg::LCG_ROW_W-1:0] em_row;
    logic [lcg_pkg::LCG_COL_W-1:0] em_col;
    logic                          em_last;
    logic                          em_eog;
    logic [8:0]                    fwin;

    assign adv   = !r_ovalid || o_result.ready;
    assign o_pop = adv && (!r_busy || em_last) && !i_empty;

    assign fwin = {1'b0, r_snew[2], r_sold[2], 1'b0, r_snew[1], r_sold[1],
                   1'b0, r_snew[0], r_sold[0]};

    always_comb begin
        em_alive = r_alive_a;
        em_row   = r_row;
        em_col   = r_col - lcg_pkg::LCG_COL_W'(1);
        em_last  = 1'b0;
        em_eog   = 1'b0;
        if (r_pa) begin
            em_last = !r_pb && !r_pf;
        end else if (r_pb) begin
            em_alive = r_alive_b;
            em_col   = r_col;
            em_last  = !r_pf;
        end else begin
            em_alive = lcg_pkg::life_rule(fwin);
            em_row   = r_frow;
            em_col   = r_fc;
            em_eog   = (r_fc == r_flast);
            em_last  = em_eog;
        end
        if (!r_busy) begin
            em_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= r_busy;
            r_busy   <= o_pop || (r_busy && !em_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_busy) begin
            r_onext <= em_alive;
            r_orow  <= em_row;
            r_ocol  <= em_col;
            r_olast <= em_last;
            r_oeog  <= em_eog;
        end
        if (o_pop) begin
            r_pa      <= i_job.has_a;
            r_pb      <= i_job.has_b;
            r_pf      <= i_job.flush;
            r_alive_a <= i_job.alive_a;
            r_alive_b <= i_job.alive_b;
            r_row     <= i_job.row;
            r_col     <= i_job.col;
            r_frow    <= i_job.frow;
            r_flast   <= i_job.flast;
            r_fc      <= '0;
            r_sold    <= {1'b0, i_job.fold, 1'b0};
            r_snew    <= {1'b0, i_job.fnew, 1'b0};
        end else if (adv && r_busy) begin
            if (r_pa) begin
                r_pa <= 1'b0;
            end else if (r_pb) begin
                r_pb <= 1'b0;
            end else begin
                r_fc   <= r_fc + lcg_pkg::LCG_COL_W'(1);
                r_sold <= r_sold >> 1;
                r_snew <= r_snew >> 1;
            end
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.next_alive  = r_onext;
    assign o_result.out_row     = r_orow;
    assign o_result.out_col     = r_ocol;
    assign o_result.last_in_run = r_olast;
    assign o_result.end_of_grid = r_oeog;

endmodule

>>> design/life_automaton_generation.sv
// A result passes through the job queue, the emitter's job registers and the output register.
// One cell per cycle in while the queue is not full; one result per cycle out while the sink is
// ready and jobs are queued; a grid's last cell adds one result per column.
// The four-entry job queue between classifier and emitter absorbs those bursts.
// Reset (synchronous, active low): position, window, queue and output valid clear;
// grid size returns to 8 x 8; line buffers keep their contents.
module life_automaton_generation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcg_pkg::LCG_ADDR_W-1:0]  paddr,
    input  logic [lcg_pkg::LCG_DATA_W-1:0]  pwdata,
    output logic [lcg_pkg::LCG_DATA_W-1:0]  prdata,
    output logic                            pready,
    lcg_cell_if.sink                        i_cell,
    lcg_result_if.source                    o_result
);

    logic [lcg_pkg::LCG_ROWS_W-1:0] r_grid_rows;
    logic [lcg_pkg::LCG_COLS_W-1:0] r_grid_cols;
    logic                           wr_en;

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    lcg_pkg::t_job front_job;
    lcg_pkg::t_job head_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lcg_pkg::LCG_ROWS_W'(8);
            r_grid_cols <= lcg_pkg::LCG_COLS_W'(8);
        end else if (wr_en) begin
            case (paddr[2])
                lcg_pkg::LCG_REG_ROWS: r_grid_rows <= pwdata[lcg_pkg::LCG_ROWS_W-1:0];
                lcg_pkg::LCG_REG_COLS: r_grid_cols <= pwdata[lcg_pkg::LCG_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lcg_pkg::LCG_REG_ROWS: prdata = lcg_pkg::LCG_DATA_W'(r_grid_rows);
            lcg_pkg::LCG_REG_COLS: prdata = lcg_pkg::LCG_DATA_W'(r_grid_cols);
            default:               prdata = '0;
        endcase
    end

    lcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_full      (full),
        .i_cell      (i_cell),
        .o_push      (push),
        .o_job       (front_job)
    );

    lcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    lcg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

>>> tb/life_automaton_generation_tb.sv
`timescale 1ns / 1ps

module life_automaton_generation_tb;

    typedef struct packed {
        logic                          next_alive;
        logic [lcg_pkg::LCG_ROW_W-1:0] out_row;
        logic [lcg_pkg::LCG_COL_W-1:0] out_col;
        logic                          last_in_run;
        logic                          end_of_grid;
    } t_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lcg_pkg::LCG_ADDR_W-1:0] paddr;
    logic [lcg_pkg::LCG_DATA_W-1:0] pwdata;
    logic [lcg_pkg::LCG_DATA_W-1:0] prdata;
    logic                           pready;

    lcg_cell_if   cell_if ();
    lcg_result_if res_if ();

    life_automaton_generation u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_cell   (cell_if),
        .o_result (res_if)
    );

    t_result             next_gen_q[$];
    int unsigned         mismatches;
    bit                  steady;

    logic [lcg_pkg::LCG_ROWS_W-1:0] grid_rows_q;
    logic [lcg_pkg::LCG_COLS_W-1:0] grid_cols_q;
    logic                           older_row [lcg_pkg::LCG_MAX_COLS];
    logic                           newer_row [lcg_pkg::LCG_MAX_COLS];
    logic [8:0]                     window_q;
    int unsigned                    next_row;
    int unsigned                    next_col;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned rows_in_use();
        if (grid_rows_q == '0) begin
            return 1;
        end
        if (grid_rows_q > lcg_pkg::LCG_MAX_ROWS) begin
            return lcg_pkg::LCG_MAX_ROWS;
        end
        return grid_rows_q;
    endfunction

    function automatic int unsigned cols_in_use();
        if (grid_cols_q == '0) begin
            return 1;
        end
        if (grid_cols_q > lcg_pkg::LCG_MAX_COLS) begin
            return lcg_pkg::LCG_MAX_COLS;
        end
        return grid_cols_q;
    endfunction

    function automatic logic life_fate(input logic alive, input int unsigned n);
        return (n == lcg_pkg::LCG_LIVE_HI) || (alive && (n == lcg_pkg::LCG_LIVE_LO));
    endfunction

    function automatic logic window_fate(input logic [8:0] w);
        int unsigned n;
        n = 0;
        for (int b = 0; b < 9; b++) begin
            if (b != 4) begin
                n += w[b];
            end
        end
        return life_fate(w[4], n);
    endfunction

    function automatic void push_result(input logic alive, input int unsigned r,
                                        input int unsigned c, input logic eog);
        t_result e;
        e.next_alive  = alive;
        e.out_row     = lcg_pkg::LCG_ROW_W'(r);
        e.out_col     = lcg_pkg::LCG_COL_W'(c);
        e.last_in_run = 1'b0;
        e.end_of_grid = eog;
        next_gen_q.push_back(e);
    endfunction

    function automatic void predict_cell(input logic alive);
        int unsigned rows;
        int unsigned cols;
        int unsigned i;
        int unsigned j;
        int unsigned made;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        logic        a;
        logic        b;
        rows = rows_in_use();
        cols = cols_in_use();
        if (next_col >= cols || next_row >= rows) begin
            next_col = 0;
            next_row = 0;
        end
        i    = next_row;
        j    = next_col;
        made = 0;
        a = (i >= 2) ? older_row[j] : 1'b0;
        b = (i >= 1) ? newer_row[j] : 1'b0;
        older_row[j] = newer_row[j];
        newer_row[j] = alive;
        if (j == 0) begin
            window_q = '0;
        end
        window_q = {alive, b, a, window_q[8:3]};
        if (i >= 1) begin
            if (j >= 1) begin
                push_result(window_fate(window_q), i - 1, j - 1, 1'b0);
                made++;
            end
            if (j == cols - 1) begin
                push_result(window_fate({3'b000, window_q[8:3]}), i - 1, j, 1'b0);
                made++;
            end
        end
        if (i == rows - 1 && j == cols - 1) begin
            for (int unsigned c = 0; c < cols; c++) begin
                n  = 0;
                lo = (c > 0) ? c - 1 : 0;
                hi = (c + 1 < cols) ? c + 1 : c;
                for (int unsigned x = lo; x <= hi; x++) begin
                    if (i >= 1) begin
                        n += older_row[x];
                    end
                    if (x != c) begin
                        n += newer_row[x];
                    end
                end
                push_result(life_fate(newer_row[c], n), i, c, c == cols - 1);
                made++;
            end
        end
        if (made > 0) begin
            next_gen_q[next_gen_q.size() - 1].last_in_run = 1'b1;
        end
        next_col = j + 1;
        if (next_col >= cols) begin
            next_col = 0;
            next_row = i + 1;
            if (next_row >= rows) begin
                next_row = 0;
            end
        end
    endfunction

    always @(negedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.next_alive  = res_if.next_alive;
            got.out_row     = res_if.out_row;
            got.out_col     = res_if.out_col;
            got.last_in_run = res_if.last_in_run;
            got.end_of_grid = res_if.end_of_grid;
            if (next_gen_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: alive %0b row %0d col %0d last %0b eog %0b",
                             got.next_alive, got.out_row, got.out_col,
                             got.last_in_run, got.end_of_grid);
                end
            end else begin
                want = next_gen_q.pop_front();
                if (got.next_alive !== want.next_alive || got.out_row !== want.out_row ||
                    got.out_col !== want.out_col || got.last_in_run !== want.last_in_run ||
                    got.end_of_grid !== want.end_of_grid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp alive %0b row %0d col %0d last %0b eog %0b",
                                 want.next_alive, want.out_row, want.out_col,
                                 want.last_in_run, want.end_of_grid);
                        $display("          got alive %0b row %0d col %0d last %0b eog %0b",
                                 got.next_alive, got.out_row, got.out_col,
                                 got.last_in_run, got.end_of_grid);
                    end
                end
            end
        end
    end

    task automatic send_cell(input logic alive);
        while (!steady && $urandom_range(99) < 8) begin
            cell_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        predict_cell(alive);
        cell_if.valid      <= 1'b1;
        cell_if.cell_alive <= alive;
        @(posedge i_clk);
        while (!cell_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic send_cells(input int unsigned count, input int unsigned density);
        for (int unsigned k = 0; k < count; k++) begin
            send_cell($urandom_range(99) < density);
        end
    endtask

    task automatic send_pattern(input logic [8:0] cells);
        for (int k = 8; k >= 0; k--) begin
            send_cell(cells[k]);
        end
    endtask

    task automatic settle();
        cell_if.valid <= 1'b0;
        while (next_gen_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [lcg_pkg::LCG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        if (idx == lcg_pkg::LCG_REG_ROWS) begin
            grid_rows_q = value[lcg_pkg::LCG_ROWS_W-1:0];
        end else begin
            grid_cols_q = value[lcg_pkg::LCG_COLS_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols);
        settle();
        write_reg(lcg_pkg::LCG_REG_ROWS, rows);
        write_reg(lcg_pkg::LCG_REG_COLS, cols);
    endtask

    task automatic test_reset_grid();
        steady = 1'b1;
        send_cells(64, 40);
        steady = 1'b0;
    endtask

    task automatic test_single_cell();
        set_grid(0, 0);
        send_cell(1'b1);
        send_cell(1'b0);
    endtask

    task automatic test_blinker();
        set_grid(3, 3);
        send_pattern(9'b010_010_010);
        send_pattern(9'b111_111_111);
    endtask

    task automatic test_resize_mid_grid();
        set_grid(4096, 4);
        send_cells(10, 50);
        settle();
        write_reg(lcg_pkg::LCG_REG_ROWS, 2);
        send_cells(8, 50);
        set_grid(4, 3);
        send_cells(4, 50);
        settle();
        write_reg(lcg_pkg::LCG_REG_ROWS, 2);
        send_cells(2, 50);
    endtask

    task automatic test_size_extremes();
        set_grid(8191, 1);
        send_cells(40, 50);
        set_grid(2, 63);
        send_cells(rows_in_use() * cols_in_use(), 45);
        set_grid(1, 32);
        send_cells(rows_in_use() * cols_in_use(), 60);
        set_grid(3, 33);
        send_cells(rows_in_use() * cols_in_use(), 100);
    endtask

    task automatic test_random_grids();
        int unsigned sent;
        int unsigned g;
        int unsigned rows;
        int unsigned cols;
        int unsigned density;
        sent = 0;
        g    = 0;
        while (sent < 110) begin
            if ($urandom_range(4) == 0) begin
                rows = $urandom_range(6, 12);
                cols = $urandom_range(1, 8);
            end else begin
                rows = $urandom_range(1, 5);
                cols = $urandom_range(1, 32);
            end
            if ($urandom_range(9) == 0) begin
                rows = ($urandom_range(1) == 0) ? 0 : 1;
            end
            if ($urandom_range(9) == 0) begin
                cols = ($urandom_range(1) == 0) ? 0 : $urandom_range(33, 63);
            end
            case ($urandom_range(3))
                0: density = 5;
                1: density = 30;
                2: density = 50;
                default: density = 75;
            endcase
            set_grid(rows, cols);
            steady = (g < 3);
            send_cells(rows_in_use() * cols_in_use(), density);
            sent += rows_in_use() * cols_in_use();
            g++;
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cell_if.valid      = 1'b0;
        cell_if.cell_alive = 1'b0;
        res_if.ready       = 1'b0;
        mismatches         = 0;
        steady             = 1'b0;
        grid_rows_q        = lcg_pkg::LCG_ROWS_W'(8);
        grid_cols_q        = lcg_pkg::LCG_COLS_W'(8);
        window_q           = '0;
        next_row           = 0;
        next_col           = 0;
        for (int k = 0; k < lcg_pkg::LCG_MAX_COLS; k++) begin
            older_row[k] = 1'b0;
            newer_row[k] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_grid();
        test_single_cell();
        test_blinker();
        test_resize_mid_grid();
        test_size_extremes();
        test_random_grids();
        settle();
        if (mismatches == 0 && next_gen_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
